FILE: src/swbs_pkg.sv
package swbs_pkg;

    // Field widths fixed by the event and result formats.
    localparam int FUNC_W   = 2;
    localparam int LEN_W    = 10;
    localparam int OPC_W    = 16;
    localparam int ALEN_W   = 3;
    localparam int SEQ_W    = 16;
    localparam int ACT_W    = 3;
    localparam int RETRY_W  = 4;
    localparam int TOTAL_W  = 32;

    // Full data block size; a shorter block ends the transfer.
    localparam int BLOCK_BYTES = 512;

    // Protocol constants.
    localparam logic [OPC_W-1:0]   ACK_OPCODE      = OPC_W'(4);
    localparam logic [ALEN_W-1:0]  ACK_BYTES       = ALEN_W'(4);
    localparam logic [RETRY_W-1:0] MAX_RETRIES_RST = RETRY_W'(10);
    localparam logic [SEQ_W-1:0]   FIRST_BLOCK     = SEQ_W'(1);

    // Queue between front and back.
    localparam int QDEPTH   = 2;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int QCOUNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [FUNC_W-1:0] {
        FN_START   = 2'd0,
        FN_BLOCK   = 2'd1,
        FN_TIMEOUT = 2'd2,
        FN_PACKET  = 2'd3
    } t_func;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE     = 3'd0,
        ACT_SEND     = 3'd1,
        ACT_RESEND   = 3'd2,
        ACT_FETCH    = 3'd3,
        ACT_COMPLETE = 3'd4,
        ACT_GIVEUP   = 3'd5
    } t_action;

    typedef enum logic [1:0] {
        PH_READY = 2'd0,
        PH_WAIT  = 2'd1,
        PH_DONE  = 2'd2
    } t_phase;

    // A classified event as it travels through the queue.
    typedef struct packed {
        t_func             func;
        logic [LEN_W-1:0]  length;
        logic              ack_ok;
        logic [SEQ_W-1:0]  seq;
    } t_item;

    // Queue status seen by the top level.
    typedef struct packed {
        logic                full;
        logic                valid;
        logic [QCOUNT_W-1:0] count;
    } t_q_status;

endpackage

FILE: src/swbs_front.sv
module swbs_front (
    input  logic [1:0]           i_func,
    input  logic [9:0]           i_block_length,
    input  logic [15:0]          i_ack_opcode,
    input  logic [2:0]           i_ack_length,
    input  logic [15:0]          i_ack_seq,
    output swbs_pkg::t_item      o_item
);
    import swbs_pkg::*;

    logic [LEN_W-1:0] len_sat;

    // Clamp an oversized block to the full block size.
    always_comb begin
        if (i_block_length > LEN_W'(BLOCK_BYTES)) begin
            len_sat = LEN_W'(BLOCK_BYTES);
        end else begin
            len_sat = i_block_length;
        end
    end

    // Classify the word; the ACK number check waits for the back end's state.
    always_comb begin
        o_item.func   = t_func'(i_func);
        o_item.length = len_sat;
        o_item.ack_ok = (i_ack_length == ACK_BYTES) && (i_ack_opcode == ACK_OPCODE);
        o_item.seq    = i_ack_seq;
    end

endmodule

FILE: src/swbs_queue.sv
module swbs_queue (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  swbs_pkg::t_item       i_item,
    input  logic                  i_pop,
    output swbs_pkg::t_item       o_item,
    output swbs_pkg::t_q_status   o_status
);
    import swbs_pkg::*;

    t_item               r_mem [QDEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCOUNT_W-1:0] r_count;

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    assign o_item         = r_mem[r_rd_ptr];
    assign o_status.full  = (r_count == QCOUNT_W'(QDEPTH));
    assign o_status.valid = (r_count != '0);
    assign o_status.count = r_count;

endmodule

FILE: src/swbs_back.sv
module swbs_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [3:0]            i_cfg_wr_data,
    input  logic                  i_q_valid,
    input  swbs_pkg::t_item       i_item,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [2:0]            o_action,
    output logic [15:0]           o_block_number,
    output logic [9:0]            o_sent_length,
    output logic [3:0]            o_retry_count,
    output logic [31:0]           o_total_blocks
);
    import swbs_pkg::*;

    logic [RETRY_W-1:0] r_max_retries;
    t_phase             r_phase, n_phase;
    logic [SEQ_W-1:0]   r_block, n_block;
    logic [RETRY_W-1:0] r_retries, n_retries;
    logic [LEN_W-1:0]   r_held, n_held;
    logic [TOTAL_W-1:0] r_acked, n_acked;
    t_action            n_action;

    logic               r_out_valid;
    t_action            r_out_action;
    logic [SEQ_W-1:0]   r_out_block;
    logic [LEN_W-1:0]   r_out_len;
    logic [RETRY_W-1:0] r_out_retries;
    logic [TOTAL_W-1:0] r_out_total;

    // Take the next word when the output register is free or being emptied.
    assign o_pop = i_q_valid && (!r_out_valid || !i_stall);

    // Retry limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_retries <= MAX_RETRIES_RST;
        end else if (i_cfg_wr_en) begin
            r_max_retries <= i_cfg_wr_data;
        end
    end

    // Transfer state machine: next state and action for one word.
    always_comb begin
        n_phase   = r_phase;
        n_block   = r_block;
        n_retries = r_retries;
        n_held    = r_held;
        n_acked   = r_acked;
        n_action  = ACT_NONE;
        case (i_item.func)
            FN_START: begin
                n_phase   = PH_READY;
                n_block   = FIRST_BLOCK;
                n_retries = '0;
                n_held    = '0;
                n_acked   = '0;
            end
            FN_BLOCK: begin
                if (r_phase == PH_READY) begin
                    n_held    = i_item.length;
                    n_retries = '0;
                    n_phase   = PH_WAIT;
                    n_action  = ACT_SEND;
                end
            end
            FN_TIMEOUT: begin
                if (r_phase == PH_WAIT) begin
                    if (r_retries >= r_max_retries) begin
                        n_phase  = PH_DONE;
                        n_action = ACT_GIVEUP;
                    end else begin
                        n_retries = r_retries + 1'b1;
                        n_action  = ACT_RESEND;
                    end
                end
            end
            FN_PACKET: begin
                if (r_phase == PH_WAIT) begin
                    n_retries = '0;
                    if (i_item.ack_ok && (i_item.seq == r_block)) begin
                        n_block = r_block + 1'b1;
                        if (r_acked != '1) begin
                            n_acked = r_acked + 1'b1;
                        end
                        if (r_held == LEN_W'(BLOCK_BYTES)) begin
                            n_phase  = PH_READY;
                            n_action = ACT_FETCH;
                        end else begin
                            n_phase  = PH_DONE;
                            n_action = ACT_COMPLETE;
                        end
                    end
                end
            end
            default: begin
                n_action = ACT_NONE;
            end
        endcase
    end

    // State registers, updated once per word taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_READY;
            r_block   <= FIRST_BLOCK;
            r_retries <= '0;
            r_held    <= '0;
            r_acked   <= '0;
        end else if (o_pop) begin
            r_phase   <= n_phase;
            r_block   <= n_block;
            r_retries <= n_retries;
            r_held    <= n_held;
            r_acked   <= n_acked;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result word register.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out_action  <= n_action;
            r_out_block   <= n_block;
            r_out_len     <= n_held;
            r_out_retries <= n_retries;
            r_out_total   <= n_acked;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_action       = r_out_action;
    assign o_block_number = r_out_block;
    assign o_sent_length  = r_out_len;
    assign o_retry_count  = r_out_retries;
    assign o_total_blocks = r_out_total;

endmodule

FILE: src/stop_and_wait_block_sender_core.sv
// Channel   Direction  Handshake             Word
// input     in         i_valid / o_stall     func, block_length, ack fields
// output    out        o_valid / i_stall     action, block, length, retries, total
// config    in         i_cfg_wr_en           max_retries
//
// One word is taken per cycle while o_stall is low; the accepting edge writes it
// into the queue. It is later popped and its result loaded into the result
// register. The transfer state machine retires one word per cycle while i_stall
// is low. A two-word queue sits between decode and the state machine, so up to
// two more words are taken while a result waits on i_stall. Reset is
// synchronous, active low, and restores the retry limit to ten.
module stop_and_wait_block_sender_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_func,
    input  logic [9:0]  i_block_length,
    input  logic [15:0] i_ack_opcode,
    input  logic [2:0]  i_ack_length,
    input  logic [15:0] i_ack_seq,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_action,
    output logic [15:0] o_block_number,
    output logic [9:0]  o_sent_length,
    output logic [3:0]  o_retry_count,
    output logic [31:0] o_total_blocks
);
    import swbs_pkg::*;

    t_item     front_item;
    t_item     q_item;
    t_q_status q_stat;
    logic      push;
    logic      pop;

    // Decode and classify incoming words.
    swbs_front u_front (
        .i_func         (i_func),
        .i_block_length (i_block_length),
        .i_ack_opcode   (i_ack_opcode),
        .i_ack_length   (i_ack_length),
        .i_ack_seq      (i_ack_seq),
        .o_item         (front_item)
    );

    assign o_stall = q_stat.full;
    assign push    = i_valid && !q_stat.full;

    // Queue between decode and the state machine.
    swbs_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (q_item),
        .o_status (q_stat)
    );

    // Transfer state machine and result register.
    swbs_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data),
        .i_q_valid      (q_stat.valid),
        .i_item         (q_item),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_action       (o_action),
        .o_block_number (o_block_number),
        .o_sent_length  (o_sent_length),
        .o_retry_count  (o_retry_count),
        .o_total_blocks (o_total_blocks)
    );

    // The queue never holds more words than it has entries.
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.count <= QCOUNT_W'(QDEPTH))
        else $error("queue fill count exceeds depth");

    // A fresh send starts with a clean retry count.
    a_send_retries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_SEND)) |-> (o_retry_count == '0))
        else $error("send reported with nonzero retry count");

    // A resend always carries at least one retry.
    a_resend_retries: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_RESEND)) |-> (o_retry_count != '0))
        else $error("resend reported with zero retry count");

    // Only a full block leads to fetching the next one.
    a_fetch_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_action == ACT_FETCH)) |-> (o_sent_length == LEN_W'(BLOCK_BYTES)))
        else $error("fetch after a short block");

endmodule

FILE: verif/swbs_checker.sv
`timescale 1ns / 100ps
module swbs_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [3:0]  i_cfg_wr_data,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic [1:0]  i_func,
    input  logic [9:0]  i_block_length,
    input  logic [15:0] i_ack_opcode,
    input  logic [2:0]  i_ack_length,
    input  logic [15:0] i_ack_seq,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [2:0]  i_action,
    input  logic [15:0] i_block_number,
    input  logic [9:0]  i_sent_length,
    input  logic [3:0]  i_retry_count,
    input  logic [31:0] i_total_blocks,
    output int          o_fail_count,
    output int          o_pending
);
    import swbs_pkg::*;

    // One result word as the sender should report it.
    typedef struct packed {
        t_action              action;
        logic [SEQ_W-1:0]     block;
        logic [LEN_W-1:0]     length;
        logic [RETRY_W-1:0]   retries;
        logic [TOTAL_W-1:0]   total;
    } t_sender_result;

    // Our own copy of the transfer state and the retry limit.
    t_phase               phase = PH_READY;
    logic [SEQ_W-1:0]     cur_block = FIRST_BLOCK;
    logic [RETRY_W-1:0]   retries = '0;
    logic [LEN_W-1:0]     held_len = '0;
    logic [TOTAL_W-1:0]   acked = '0;
    logic [RETRY_W-1:0]   retry_limit = MAX_RETRIES_RST;

    t_sender_result       due_words[$];
    int                   fail_count = 0;
    int                   due_count = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_sender_result want;
        t_action        verdict;
        if (!i_rst_n) begin
            phase       = PH_READY;
            cur_block   = FIRST_BLOCK;
            retries     = '0;
            held_len    = '0;
            acked       = '0;
            retry_limit = MAX_RETRIES_RST;
            due_words.delete();
        end else begin
            if (i_cfg_wr_en) begin
                retry_limit = i_cfg_wr_data;
            end

            // Compare a delivered word against the oldest prediction.
            if (i_out_valid && !i_out_stall) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected word, action %0d block %0d length %0d",
                             $time, i_action, i_block_number, i_sent_length);
                    fail_count++;
                end else begin
                    want = due_words.pop_front();
                    check_field("action", 32'(want.action), 32'(i_action));
                    check_field("block_number", 32'(want.block), 32'(i_block_number));
                    check_field("sent_length", 32'(want.length), 32'(i_sent_length));
                    check_field("retry_count", 32'(want.retries), 32'(i_retry_count));
                    check_field("total_blocks", want.total, i_total_blocks);
                end
            end

            // Advance the transfer state for an accepted event word.
            if (i_in_valid && !i_in_stall) begin
                verdict = ACT_NONE;
                case (t_func'(i_func))
                    FN_START: begin
                        phase     = PH_READY;
                        cur_block = FIRST_BLOCK;
                        retries   = '0;
                        held_len  = '0;
                        acked     = '0;
                    end
                    FN_BLOCK: begin
                        if (phase == PH_READY) begin
                            // Oversized blocks are clipped to a full block.
                            held_len = (i_block_length > LEN_W'(BLOCK_BYTES)) ?
                                       LEN_W'(BLOCK_BYTES) : i_block_length;
                            retries  = '0;
                            phase    = PH_WAIT;
                            verdict  = ACT_SEND;
                        end
                    end
                    FN_TIMEOUT: begin
                        if (phase == PH_WAIT) begin
                            if (retries >= retry_limit) begin
                                phase   = PH_DONE;
                                verdict = ACT_GIVEUP;
                            end else begin
                                retries = retries + 1'b1;
                                verdict = ACT_RESEND;
                            end
                        end
                    end
                    default: begin
                        // Any packet while waiting clears the retries; only a
                        // matching, well-formed ACK moves the transfer on.
                        if (phase == PH_WAIT) begin
                            retries = '0;
                            if (i_ack_length == ACK_BYTES && i_ack_opcode == ACK_OPCODE &&
                                i_ack_seq == cur_block) begin
                                cur_block = cur_block + 1'b1;
                                if (acked != '1) begin
                                    acked = acked + 1'b1;
                                end
                                if (held_len == LEN_W'(BLOCK_BYTES)) begin
                                    phase   = PH_READY;
                                    verdict = ACT_FETCH;
                                end else begin
                                    phase   = PH_DONE;
                                    verdict = ACT_COMPLETE;
                                end
                            end
                        end
                    end
                endcase
                due_words.push_back('{verdict, cur_block, held_len, retries, acked});
            end
        end
        due_count = due_words.size();
    end

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import swbs_pkg::*;

    localparam int IDLE_LIMIT   = 4000;
    localparam int RANDOM_WORDS = 400;

    typedef enum int {RX_OPEN, RX_JITTER, RX_SPARSE, RX_BLOCKED} t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [3:0]  cfg_wr_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  func = '0;
    logic [9:0]  block_length = '0;
    logic [15:0] ack_opcode = '0;
    logic [2:0]  ack_length = '0;
    logic [15:0] ack_seq = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  action;
    logic [15:0] block_number;
    logic [9:0]  sent_length;
    logic [3:0]  retry_count;
    logic [31:0] total_blocks;

    int          fail_count;
    int          pending;

    // Stimulus bookkeeping.
    bit          quiet = 1'b0;
    int          burst_left = 0;
    int          retry_limit = MAX_RETRIES_RST;
    int          counted = 0;
    int          idle_cycles = 0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_left = 0;

    stop_and_wait_block_sender_core dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_valid        (in_valid),
        .o_stall        (in_stall),
        .i_func         (func),
        .i_block_length (block_length),
        .i_ack_opcode   (ack_opcode),
        .i_ack_length   (ack_length),
        .i_ack_seq      (ack_seq),
        .o_valid        (out_valid),
        .i_stall        (out_stall),
        .o_action       (action),
        .o_block_number (block_number),
        .o_sent_length  (sent_length),
        .o_retry_count  (retry_count),
        .o_total_blocks (total_blocks)
    );

    swbs_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_wr_en    (cfg_wr_en),
        .i_cfg_wr_data  (cfg_wr_data),
        .i_in_valid     (in_valid),
        .i_in_stall     (in_stall),
        .i_func         (func),
        .i_block_length (block_length),
        .i_ack_opcode   (ack_opcode),
        .i_ack_length   (ack_length),
        .i_ack_seq      (ack_seq),
        .i_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .i_action       (action),
        .i_block_number (block_number),
        .i_sent_length  (sent_length),
        .i_retry_count  (retry_count),
        .i_total_blocks (total_blocks),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure: stretches of open, jittery, sparse or solid stalls.
    always @(negedge clk) begin
        if (!rst_n || quiet) begin
            out_stall = 1'b0;
        end else begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(4, 40);
            end
            rx_left--;
            case (rx_mode)
                RX_OPEN:    out_stall = 1'b0;
                RX_JITTER:  out_stall = 1'($urandom_range(0, 1));
                RX_SPARSE:  out_stall = ($urandom_range(0, 7) == 0);
                default:    out_stall = 1'b1;
            endcase
        end
    end

    // Watchdog on cycles where neither channel moves a word.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Present one event word and hold it until the block takes it. Entered and
    // left at a falling edge; valid stays high for back-to-back words.
    task automatic post_event(input t_func f, input logic [9:0] len,
                              input logic [15:0] opc, input logic [2:0] alen,
                              input logic [15:0] seq);
        int gap;
        if (!quiet && burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0) begin
                in_valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        if (burst_left > 0) begin
            burst_left--;
        end
        func         = f;
        block_length = len;
        ack_opcode   = opc;
        ack_length   = alen;
        ack_seq      = seq;
        in_valid     = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        counted++;
        @(negedge clk);
    endtask

    task automatic start_transfer();
        post_event(FN_START, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic block_ready(input logic [9:0] len);
        post_event(FN_BLOCK, len, 16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                   16'($urandom_range(0, 65535)));
    endtask

    task automatic tick();
        post_event(FN_TIMEOUT, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                   3'($urandom_range(0, 7)), 16'($urandom_range(0, 65535)));
    endtask

    task automatic ack(input logic [15:0] seq);
        post_event(FN_PACKET, 10'($urandom_range(0, 1023)), ACK_OPCODE, ACK_BYTES, seq);
    endtask

    // A packet that must not count as the ACK for the given block.
    task automatic stray_packet(input logic [15:0] blk);
        logic [15:0] opc;
        logic [15:0] seq;
        logic [2:0]  alen;
        opc  = 16'($urandom_range(0, 65535));
        alen = 3'($urandom_range(0, 7));
        seq  = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 2))
            0: begin
                opc  = ACK_OPCODE;
                alen = ACK_BYTES;
                seq  = blk + 16'd1;
            end
            1: begin
                opc = ACK_OPCODE;
                seq = blk;
            end
            default: ;
        endcase
        if (opc == ACK_OPCODE && alen == ACK_BYTES && seq == blk) begin
            seq = ~blk;
        end
        post_event(FN_PACKET, 10'($urandom_range(0, 1023)), opc, alen, seq);
    endtask

    // Let the block drain, then rewrite the retry limit.
    task automatic retune_retry_limit(input logic [3:0] value);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_wr_data = value;
        cfg_wr_en   = 1'b1;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
        retry_limit = int'(value);
    endtask

    // One file transfer: blocks with timeouts, stray packets and ACKs.
    task automatic run_transfer();
        int          nblocks;
        int          storm;
        int          tries;
        logic [9:0]  len;
        logic [15:0] blk;
        bit          over;
        nblocks = $urandom_range(1, 5);
        if ($urandom_range(0, 9) != 0) begin
            start_transfer();
        end
        blk  = FIRST_BLOCK;
        over = 1'b0;
        for (int b = 0; b < nblocks && !over; b++) begin
            if (b == nblocks - 1) begin
                len = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(0, 1023))
                                                  : 10'($urandom_range(0, 511));
            end else begin
                len = ($urandom_range(0, 4) == 0) ? 10'($urandom_range(512, 1023))
                                                  : 10'd512;
            end
            block_ready(len);
            tries = 0;
            storm = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
            for (int t = 0; t < storm && !over; t++) begin
                if ($urandom_range(0, 7) == 0) begin
                    stray_packet(blk);
                    tries = 0;
                end
                tick();
                if (tries >= retry_limit) begin
                    over = 1'b1;
                end else begin
                    tries++;
                end
            end
            if (!over) begin
                if ($urandom_range(0, 3) == 0) begin
                    stray_packet(blk);
                end
                ack(blk);
                blk = blk + 16'd1;
                if (len < 10'd512) begin
                    over = 1'b1;
                end
            end
        end
        // Trailing events, mostly ignored once the transfer has ended.
        if ($urandom_range(0, 3) == 0) begin
            post_event(t_func'($urandom_range(1, 3)), 10'($urandom_range(0, 1023)),
                       16'($urandom_range(0, 65535)), 3'($urandom_range(0, 7)),
                       16'($urandom_range(0, 65535)));
        end
    endtask

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: events in the wrong phase, bad packets, retries and clipping.
        ack(16'd1);
        tick();
        block_ready(10'd512);
        block_ready(10'd100);
        post_event(FN_PACKET, 10'd0, 16'hFFFF, ACK_BYTES, 16'd1);
        tick();
        tick();
        post_event(FN_PACKET, 10'd1023, ACK_OPCODE, 3'd3, 16'd1);
        ack(16'hFFFF);
        ack(16'd1);
        block_ready(10'd1023);
        ack(16'd2);
        block_ready(10'd0);
        ack(16'd3);
        tick();
        block_ready(10'd511);
        ack(16'd4);
        start_transfer();

        // No retries allowed: the first timeout gives up; start also aborts a wait.
        retune_retry_limit(4'd0);
        block_ready(10'd513);
        start_transfer();
        block_ready(10'd513);
        tick();
        start_transfer();

        // Short file at full rate with no receiver stalls.
        retune_retry_limit(4'd15);
        quiet = 1'b1;
        start_transfer();
        for (int i = 1; i <= 8; i++) begin
            block_ready(10'd512);
            ack(16'(i));
        end
        block_ready(10'd3);
        ack(16'd9);
        quiet = 1'b0;

        // Random transfers with occasional changes of the retry limit.
        while (counted < RANDOM_WORDS) begin
            if ($urandom_range(0, 3) == 0) begin
                case ($urandom_range(0, 3))
                    0:       retune_retry_limit(4'd0);
                    1:       retune_retry_limit(4'd15);
                    default: retune_retry_limit(4'($urandom_range(0, 15)));
                endcase
            end
            quiet = ($urandom_range(0, 4) == 0);
            run_transfer();
        end
        quiet = 1'b0;

        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
